// File: hdl/acev_pkg.sv
package acev_pkg;

  // Default number of coefficient slots.
  localparam int MAX_COEFFS = 16;

  // Samples over one turn of the angle; the sample index is a 10-bit field.
  localparam int SAMPLES = 1024;
  localparam int IDX_W = $clog2(SAMPLES);
  localparam int HALF_SAMPLES = SAMPLES / 2;
  localparam int QUARTER_SAMPLES = SAMPLES / 4;

  // The sine table covers the half turn from 0 to pi, ends included.
  localparam int ROM_DEPTH = HALF_SAMPLES + 1;
  localparam int ROM_AW = $clog2(ROM_DEPTH);
  localparam int ROM_W = 15;

  // Field widths.
  localparam int COUNT_W = 5;
  localparam int SLOT_W = 4;
  localparam int COEFF_W = 32;
  localparam int OUT_W = 48;

  // Angle constants in Q30.
  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
  localparam logic [63:0] PI_Q30 = 64'd3373259426;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // 1/sqrt(2) in Q30 for the constant term.
  localparam logic signed [31:0] INV_SQRT2_Q30 = 32'sd759250125;

  // Half an LSB of the Q16.16 result in the Q31 fraction domain.
  localparam int FRAC_SHIFT = 15;
  localparam int ROUND_Q15 = 1 << (FRAC_SHIFT - 1);

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } acev_state_t;

  // Magnitude of sin(a) in Q1.15 for an angle a in Q30 within [0, pi].
  // Eight-term Taylor series on the angle folded into [0, pi/2], rounded half up.
  function automatic logic [ROM_W-1:0] sin_mag(input logic [63:0] ang);
    logic [63:0] a;
    logic [63:0] x2;
    logic [63:0] term;
    longint s;
    longint r;
    a = (ang > HALF_PI_Q30) ? (PI_Q30 - ang) : ang;
    x2 = (a * a) >> 30;
    s = longint'(a);
    term = ((a * x2) >> 30) / 64'd6;
    s = s - longint'(term);
    term = ((term * x2) >> 30) / 64'd20;
    s = s + longint'(term);
    term = ((term * x2) >> 30) / 64'd42;
    s = s - longint'(term);
    term = ((term * x2) >> 30) / 64'd72;
    s = s + longint'(term);
    term = ((term * x2) >> 30) / 64'd110;
    s = s - longint'(term);
    term = ((term * x2) >> 30) / 64'd156;
    s = s + longint'(term);
    term = ((term * x2) >> 30) / 64'd210;
    s = s - longint'(term);
    if (s < 0) begin
      s = 0;
    end
    r = (s + 64'sd16384) >>> 15;
    if (r > 32767) begin
      r = 32767;
    end
    return ROM_W'(r);
  endfunction

endpackage

// File: hdl/andrews_curve_evaluator_unit.sv
// Andrews curve evaluator. A load item (mode 0) writes one signed Q16.16
// coefficient into slot coeff_slot; loads to slots at or above MaxCoeffs are
// dropped. An evaluate item (mode 1) returns the curve value at
// t = -pi + k*2pi/1024 as a saturated Q16.16 number: x0/sqrt2 plus, for each
// i, x[2i-1]*sin(i*t) and x[2i]*cos(i*t) over the first coeff_count
// coefficients (an even count ends on a lone sine term). All terms go one per
// cycle through a single 32x32 multiplier and accumulator, so an evaluation
// occupies the input side through the accept cycle, the issue of each term, the
// store/table read and product register, and the hand-off of the rounded sum,
// which waits until the output register is free. The output register lets a
// finished result wait while load items are taken. Sine values come from a
// 513-entry half-wave table with a registered read. Slots must be loaded before
// an evaluation reads them. The user must write coeff_count through cfg_wr_en
// only while the block is idle; the block does not enforce this. 0 acts as 1
// and values above MaxCoeffs act as MaxCoeffs.
module andrews_curve_evaluator_unit
  import acev_pkg::*;
#(
  parameter int MaxCoeffs = MAX_COEFFS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [COUNT_W-1:0]        cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_mode,
  input  logic [SLOT_W-1:0]         in_coeff_slot,
  input  logic signed [COEFF_W-1:0] in_coeff_value,
  input  logic [IDX_W-1:0]          in_sample_index,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [OUT_W-1:0]   out_curve_value
);

  localparam int AddrW = (MaxCoeffs > 1) ? $clog2(MaxCoeffs) : 1;
  // Every term is below 2^46 in magnitude, so this width holds any sum.
  localparam int AccW = OUT_W + $clog2(MaxCoeffs);
  // The constant term multiplies by 1/sqrt2 in Q30 and needs the full product.
  localparam int ProdW = 64;

  acev_state_t state_r, state_nxt;

  logic [COUNT_W-1:0]        cfg_count_r;
  logic [AddrW-1:0]          term_r;
  logic [AddrW-1:0]          last_r;
  logic [AddrW-1:0]          last_nxt;
  logic [IDX_W-1:0]          phase_r;
  logic [IDX_W-1:0]          step_r;
  logic [IDX_W-1:0]          base_nxt;

  logic                      issue;
  logic                      out_load;
  logic                      eval_start;
  logic                      load_we;

  logic [IDX_W-1:0]          ang;
  logic [IDX_W-1:0]          ang_flip;
  logic                      fold_neg;
  logic [ROM_AW-1:0]         rom_idx;
  logic [ROM_W-1:0]          sin_rom [ROM_DEPTH];

  logic                      s1_valid_r;
  logic                      s1_first_r;
  logic                      s1_neg_r;
  logic                      s1_last_r;
  logic [ROM_W-1:0]          rom_q_r;
  logic [COEFF_W-1:0]        coeff_q;

  logic signed [31:0]        mag;
  logic signed [31:0]        b_op;
  logic signed [63:0]        product;
  logic signed [ProdW-1:0]   prod_nxt;

  logic                      s2_valid_r;
  logic                      s2_first_r;
  logic                      s2_last_r;
  logic signed [ProdW-1:0]   prod_r;
  logic signed [ProdW-1:0]   prod_rnd;
  logic signed [AccW-1:0]    addend;
  logic signed [AccW-1:0]    acc_r, acc_nxt;
  logic signed [AccW-1:0]    acc_rnd;

  logic                      out_valid_r;
  logic signed [OUT_W-1:0]   out_value_r;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_count_r <= COUNT_W'(1);
    end else if (cfg_wr_en) begin
      cfg_count_r <= cfg_wr_data;
    end
  end

  // Index of the last term from the clamped coefficient count.
  always_comb begin
    if (cfg_count_r == '0) begin
      last_nxt = '0;
    end else if (int'(cfg_count_r) > MaxCoeffs) begin
      last_nxt = AddrW'(MaxCoeffs - 1);
    end else begin
      last_nxt = AddrW'(cfg_count_r - COUNT_W'(1));
    end
  end

  // Angle step per harmonic: k - SAMPLES/2 modulo SAMPLES.
  assign base_nxt = in_sample_index + IDX_W'(HALF_SAMPLES);

  assign eval_start = in_valid && in_ready && in_mode;
  assign load_we = in_valid && in_ready && !in_mode && (int'(in_coeff_slot) < MaxCoeffs);

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (eval_start) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (term_r == last_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (s2_valid_r && s2_last_r) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready = 1'b0;
    issue = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      ST_IDLE:   in_ready = 1'b1;
      ST_RUN:    issue = 1'b1;
      ST_DRAIN:  ;
      ST_FINISH: out_load = !out_valid_r || out_ready;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Term counter and harmonic phase. The phase holds i*base and moves on
  // after each cosine term, since the next term starts the next harmonic.
  always_ff @(posedge clk) begin
    if (eval_start) begin
      term_r <= '0;
      last_r <= last_nxt;
      phase_r <= base_nxt;
      step_r <= base_nxt;
    end else if (issue) begin
      term_r <= term_r + AddrW'(1);
      if (!term_r[0] && (term_r != '0)) begin
        phase_r <= phase_r + step_r;
      end
    end
  end

  // Odd terms read sine, even terms cosine a quarter turn later. The second
  // half turn mirrors the first with the sign flipped.
  assign ang = term_r[0] ? phase_r : phase_r + IDX_W'(QUARTER_SAMPLES);
  assign ang_flip = '0 - ang;
  assign fold_neg = ang > IDX_W'(HALF_SAMPLES);
  assign rom_idx = fold_neg ? ROM_AW'(ang_flip) : ROM_AW'(ang);

  // Sine table, built at elaboration.
  for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_rom
    localparam logic [63:0] Angle = (TWO_PI_Q30 * 64'(g)) / 64'(SAMPLES);
    assign sin_rom[g] = sin_mag(Angle);
  end

  // Coefficient store.
  acev_ram #(
    .Width (COEFF_W),
    .Depth (MaxCoeffs)
  ) u_coeff_store (
    .clk   (clk),
    .we    (load_we),
    .waddr (AddrW'(in_coeff_slot)),
    .wdata (in_coeff_value),
    .raddr (term_r),
    .rdata (coeff_q)
  );

  // Read stage: table read lines up with the store read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    rom_q_r <= sin_rom[rom_idx];
    s1_first_r <= (term_r == '0);
    s1_neg_r <= fold_neg;
    s1_last_r <= (term_r == last_r);
  end

  // Shared multiplier: 1/sqrt2 for the constant term, else the signed table value.
  assign mag = 32'($signed({1'b0, rom_q_r}));
  assign b_op = s1_first_r ? INV_SQRT2_Q30 : (s1_neg_r ? -mag : mag);
  assign product = $signed(coeff_q) * b_op;
  assign prod_nxt = ProdW'(product);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    s2_first_r <= s1_first_r;
    s2_last_r <= s1_last_r;
  end

  // Accumulator. The constant term is rounded to Q31 fraction bits first.
  assign prod_rnd = prod_r + ProdW'(ROUND_Q15);
  assign addend = s2_first_r ? AccW'(prod_rnd >>> FRAC_SHIFT) : AccW'(prod_r);

  always_comb begin
    acc_nxt = acc_r;
    if (s2_valid_r) begin
      acc_nxt = s2_first_r ? addend : acc_r + addend;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  // Round to Q16.16. The sum never exceeds the output range, so the
  // saturation reduces to sign extension or dropping redundant sign bits.
  assign acc_rnd = acc_r + AccW'(ROUND_Q15);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value_r <= OUT_W'(acc_rnd >>> FRAC_SHIFT);
    end
  end

  assign out_valid = out_valid_r;
  assign out_curve_value = out_value_r;

endmodule

// File: hdl/acev_ram.sv
module acev_ram #(
  parameter int Width = 32,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [Width-1:0] rdata
);

  logic [Width-1:0] mem [Depth];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/acev_checker.sv
module acev_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_mode,
  input logic        out_valid,
  input logic        out_ready,
  input logic [47:0] out_curve_value
);

  // A stalled result item holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_curve_value))
    else $error("result item changed while stalled");

  // A load item leaves the block ready again in the next cycle.
  a_load_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_mode |=> in_ready)
    else $error("block busy after a load item");

  // An evaluate item keeps the block busy in the next cycle.
  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode |=> !in_ready)
    else $error("block ready right after an evaluate item");

  // A new result only appears at the end of an evaluation.
  a_result_after_eval: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result item appeared while the block was idle");

endmodule

bind andrews_curve_evaluator_unit acev_checker u_acev_checker (.*);

// File: bench/tb_andrews_curve_evaluator_unit.sv
`timescale 1ns / 1ps

module tb_andrews_curve_evaluator_unit;
  import acev_pkg::*;

  // Input item modes.
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_EVAL = 1'b1;

  // Cycles allowed for an evaluation still in flight before a count write,
  // and for the tail of the run.
  localparam int DRAIN_CYCLES = 2 * MAX_COEFFS + 8;
  localparam int TAIL_CYCLES = 2 * MAX_COEFFS + 8;
  localparam int STALL_LIMIT = 2000;
  localparam int REPORT_LIMIT = 10;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 50;

  // Kinds of rows in the directed plan.
  typedef enum logic [1:0] {
    ROW_LOAD,
    ROW_EVAL,
    ROW_CFG
  } row_kind_t;

  typedef struct {
    row_kind_t          kind;
    logic [3:0]         slot;
    logic [31:0]        value;
    logic [9:0]         idx;
    bit                 typed;
    logic signed [47:0] want;
  } plan_row_t;

  localparam int PLAN_ROWS = 32;

  // Directed plan. For a count row the value holds the new coefficient count.
  // Rows with typed set carry a result that is plain from the inputs.
  plan_row_t directed_plan [PLAN_ROWS] = '{
    '{ROW_LOAD, 4'd0,  32'h00000000, 10'd0,    1'b0, 48'sd0},
    '{ROW_EVAL, 4'd0,  32'h00000000, 10'd0,    1'b1, 48'sd0},
    '{ROW_EVAL, 4'd0,  32'h00000000, 10'd1023, 1'b1, 48'sd0},
    '{ROW_LOAD, 4'd0,  32'h7FFFFFFF, 10'd0,    1'b0, 48'sd0},
    '{ROW_EVAL, 4'd0,  32'h00000000, 10'd0,    1'b0, 48'sd0},
    '{ROW_LOAD, 4'd0,  32'h80000000, 10'd0,    1'b0, 48'sd0},
    '{ROW_EVAL, 4'd0,  32'h00000000, 10'd1023, 1'b0, 48'sd0},
    '{ROW_CFG,  4'd0,  32'd16,       10'd0,    1'b0, 48'sd0},
    '{ROW_LOAD, 4'd1,  32'h7FFFFFFF, 10'd0,    1'b0, 48'sd0},
    '{ROW_LOAD, 4'd2,  32'h80000000, 10'd0,    1'b0, 48'sd0},
    '{ROW_LOAD, 4'd3,  32'h7FFFFFFF, 10'd0,    1'b0, 48'sd0},
    '{ROW_LOAD, 4'd4,  32'h80000000, 10'd0,    1'b0, 48'sd0},
    '{ROW_LOAD, 4'd5,  32'h7FFFFFFF, 10'd0,    1'b0, 48'sd0},
    '{ROW_LOAD, 4'd6,  32'h80000000, 10'd0,    1'b0, 48'sd0},
    '{ROW_LOAD, 4'd7,  32'h7FFFFFFF, 10'd0,    1'b0, 48'sd0},
    '{ROW_LOAD, 4'd8,  32'h80000000, 10'd0,    1'b0, 48'sd0},
    '{ROW_LOAD, 4'd9,  32'h7FFFFFFF, 10'd0,    1'b0, 48'sd0},
    '{ROW_LOAD, 4'd10, 32'h80000000, 10'd0,    1'b0, 48'sd0},
    '{ROW_LOAD, 4'd11, 32'h7FFFFFFF, 10'd0,    1'b0, 48'sd0},
    '{ROW_LOAD, 4'd12, 32'h80000000, 10'd0,    1'b0, 48'sd0},
    '{ROW_LOAD, 4'd13, 32'h7FFFFFFF, 10'd0,    1'b0, 48'sd0},
    '{ROW_LOAD, 4'd14, 32'h80000000, 10'd0,    1'b0, 48'sd0},
    '{ROW_LOAD, 4'd15, 32'h7FFFFFFF, 10'd0,    1'b0, 48'sd0},
    '{ROW_EVAL, 4'd0,  32'h00000000, 10'd0,    1'b0, 48'sd0},
    '{ROW_EVAL, 4'd0,  32'h00000000, 10'd512,  1'b0, 48'sd0},
    '{ROW_EVAL, 4'd0,  32'h00000000, 10'd1023, 1'b0, 48'sd0},
    '{ROW_CFG,  4'd0,  32'd0,        10'd0,    1'b0, 48'sd0},
    '{ROW_EVAL, 4'd0,  32'h00000000, 10'd256,  1'b0, 48'sd0},
    '{ROW_CFG,  4'd0,  32'd31,       10'd0,    1'b0, 48'sd0},
    '{ROW_EVAL, 4'd0,  32'h00000000, 10'd768,  1'b0, 48'sd0},
    '{ROW_CFG,  4'd0,  32'd2,        10'd0,    1'b0, 48'sd0},
    '{ROW_EVAL, 4'd0,  32'h00000000, 10'd300,  1'b0, 48'sd0}
  };

  logic                      clk;
  logic                      rst_n = 1'b0;
  logic                      cfg_wr_en = 1'b0;
  logic [COUNT_W-1:0]        cfg_wr_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic                      in_mode = MODE_LOAD;
  logic [SLOT_W-1:0]         in_coeff_slot = '0;
  logic signed [COEFF_W-1:0] in_coeff_value = '0;
  logic [IDX_W-1:0]          in_sample_index = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [OUT_W-1:0]   out_curve_value;

  // Typed expectation that travels with the item on the input port.
  bit                        row_typed = 1'b0;
  logic signed [OUT_W-1:0]   row_want = '0;

  // Predictor state: coefficient store and count in use.
  logic signed [COEFF_W-1:0] coeff_mem [MAX_COEFFS];
  logic [COUNT_W-1:0]        active_count = 5'd1;

  logic signed [OUT_W-1:0]   pending_curves [$];
  int                        fail_count = 0;
  int                        idle_cycles = 0;
  int                        ready_hold = 0;
  bit                        quiet = 1'b0;

  andrews_curve_evaluator_unit uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_coeff_slot   (in_coeff_slot),
    .in_coeff_value  (in_coeff_value),
    .in_sample_index (in_sample_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_curve_value (out_curve_value)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Table value sin(2*pi*num/den) in Q1.15 by a Taylor series in Q30.
  function automatic longint rom_sine(input logic [63:0] num, input logic [63:0] den);
    logic        neg;
    logic [63:0] n;
    logic [63:0] a;
    logic [63:0] x2;
    logic [63:0] term;
    longint      s;
    longint      r;
    n = num % den;
    neg = 1'b0;
    if (2 * n > den) begin
      neg = 1'b1;
      n = den - n;
    end
    a = (TWO_PI_Q30 * n) / den;
    if (a > HALF_PI_Q30) begin
      a = PI_Q30 - a;
    end
    x2 = (a * a) >> 30;
    term = a;
    s = longint'(a);
    for (int j = 1; j <= 7; j++) begin
      term = ((term * x2) >> 30) / 64'((2 * j) * (2 * j + 1));
      if (j % 2 == 1) begin
        s = s - longint'(term);
      end else begin
        s = s + longint'(term);
      end
    end
    if (s < 0) begin
      s = 0;
    end
    r = (s + 64'sd16384) >>> 15;
    if (r > 32767) begin
      r = 32767;
    end
    return neg ? -r : r;
  endfunction

  // Curve value at sample k over the coefficients in use, Q16.16 saturated.
  function automatic logic signed [OUT_W-1:0] curve_at(input logic [IDX_W-1:0] k);
    int unsigned n;
    int unsigned pairs;
    logic [63:0] base;
    logic [63:0] m;
    longint      acc;
    longint      res;
    n = active_count;
    if (n == 0) begin
      n = 1;
    end
    if (n > MAX_COEFFS) begin
      n = MAX_COEFFS;
    end
    pairs = (n - 1) / 2;
    base = (64'(k) + SAMPLES - HALF_SAMPLES) % SAMPLES;
    acc = (longint'(coeff_mem[0]) * longint'(INV_SQRT2_Q30) + 64'sd16384) >>> 15;
    for (int unsigned i = 1; i <= pairs; i++) begin
      m = (64'(i) * base) % SAMPLES;
      acc += longint'(coeff_mem[2 * i - 1]) * rom_sine(m, SAMPLES);
      acc += longint'(coeff_mem[2 * i]) * rom_sine(4 * m + SAMPLES, 4 * SAMPLES);
    end
    // An even count ends on a lone sine term.
    if ((n - 1) % 2 == 1) begin
      m = (64'(pairs + 1) * base) % SAMPLES;
      acc += longint'(coeff_mem[2 * pairs + 1]) * rom_sine(m, SAMPLES);
    end
    res = (acc + 64'sd16384) >>> 15;
    if (res > 64'sd140737488355327) begin
      res = 64'sd140737488355327;
    end
    if (res < -64'sd140737488355328) begin
      res = -64'sd140737488355328;
    end
    return OUT_W'(res);
  endfunction

  // Present one item and hold it until the block takes it.
  task automatic send_item(input logic mode, input logic [3:0] slot,
                           input logic [31:0] value, input logic [9:0] idx,
                           input bit typed, input logic signed [47:0] want);
    in_valid <= 1'b1;
    in_mode <= mode;
    in_coeff_slot <= slot;
    in_coeff_value <= value;
    in_sample_index <= idx;
    row_typed <= typed;
    row_want <= want;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
  endtask

  // Random hold-off of the sender between items.
  task automatic maybe_pause();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // Change the coefficient count once the block has gone idle. The task waits
  // for the clock first so that the item just taken is already in the queue.
  task automatic set_count(input logic [COUNT_W-1:0] count);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_curves.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= count;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Result checking and prediction on every accepted item.
  always @(posedge clk) begin
    logic signed [OUT_W-1:0] want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_curves.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT) begin
            $display("unexpected result: curve_value %0d", out_curve_value);
          end
        end else begin
          want = pending_curves.pop_front();
          if (out_curve_value !== want) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
              $display("curve_value mismatch: expected %0d (%h), got %0d (%h)",
                       want, want, out_curve_value, out_curve_value);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        if (in_mode == MODE_LOAD) begin
          if (in_coeff_slot < MAX_COEFFS) begin
            coeff_mem[in_coeff_slot] = in_coeff_value;
          end
        end else if (row_typed) begin
          pending_curves.push_back(row_want);
        end else begin
          pending_curves.push_back(curve_at(in_sample_index));
        end
      end
      if (cfg_wr_en) begin
        active_count = cfg_wr_data;
      end
    end
  end

  // Receiver readiness in random bursts; always ready in the quiet part.
  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (quiet) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 3) != 0);
      ready_hold <= $urandom_range(0, 13);
    end
  end

  // Watchdog on cycles in which nothing moves.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_andrews_curve_evaluator_unit: errors");
      $finish;
    end
  end

  // Stimulus: directed plan, then random phases over several counts.
  initial begin
    logic [COUNT_W-1:0] count;
    logic [31:0]        value;
    logic [31:0]        raw;
    logic               mode;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < PLAN_ROWS; r++) begin
      if (directed_plan[r].kind == ROW_CFG) begin
        set_count(directed_plan[r].value[COUNT_W-1:0]);
      end else begin
        send_item((directed_plan[r].kind == ROW_EVAL) ? MODE_EVAL : MODE_LOAD,
                  directed_plan[r].slot, directed_plan[r].value, directed_plan[r].idx,
                  directed_plan[r].typed, directed_plan[r].want);
        maybe_pause();
      end
    end

    // Every slot is loaded by now, so any count may be evaluated.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: count = 5'd1;
        1: count = 5'd16;
        2: count = 5'd0;
        3: count = 5'd31;
        default: count = COUNT_W'($urandom_range(0, 31));
      endcase
      set_count(count);
      if (p == PHASES - 1) begin
        quiet = 1'b1;
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        raw = $urandom;
        case ($urandom_range(0, 7))
          0, 1: value = $urandom;
          2, 3: value = {{14{raw[17]}}, raw[17:0]};
          4: value = 32'h7FFFFFFF;
          5: value = 32'h80000000;
          6: value = 32'h00000000;
          default: value = raw & 32'hFFFF0000;
        endcase
        mode = ($urandom_range(0, 1) == 1) ? MODE_EVAL : MODE_LOAD;
        send_item(mode, SLOT_W'($urandom_range(0, 15)), value,
                  IDX_W'($urandom_range(0, 1023)), 1'b0, '0);
        maybe_pause();
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_curves.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_curves.size() == 0) begin
      $display("tb_andrews_curve_evaluator_unit: clean");
    end else begin
      $display("tb_andrews_curve_evaluator_unit: errors");
    end
    $finish;
  end

endmodule
